### design/fbdp_pkg.sv
// Shared types, constants and IEEE single helpers for the bf16/fp32 dot product.
package fbdp_pkg;

    localparam int unsigned Bf16Shift = 16;
    localparam logic [31:0] CanonNan  = 32'h7FC0_0000;

    // register indexes
    localparam logic [0:0] RegDataFormat = 1'b0;

    // unpacked IEEE single operand with special-case flags
    typedef struct packed {
        logic        sign;
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        logic signed [9:0] exp;     // unbiased, subnormals at -126
        logic [23:0] man;           // with hidden bit
    } fp_unp_t;

    // one word passed from the front to the back
    typedef struct packed {
        logic [31:0] prod;
        logic        last;
    } fbdp_word_t;

    function automatic fp_unp_t fp_unpack(input logic [31:0] b);
        fp_unp_t u;
        u.sign    = b[31];
        u.is_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        u.is_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        u.is_zero = (b[30:0] == 31'd0);
        if (b[30:23] == 8'd0) begin
            u.exp = -10'sd126;
            u.man = {1'b0, b[22:0]};
        end else begin
            u.exp = $signed({2'b00, b[30:23]}) - 10'sd127;
            u.man = {1'b1, b[22:0]};
        end
        return u;
    endfunction

    // Round a positive value m * 2^(e) where m has its leading one at bit 26 or
    // below (bits [2:0] are guard/round/sticky, binary point after bit 26),
    // normalized so m[26] is set unless the value is tiny.
    // e is the exponent of bit 26. Returns the packed single.
    function automatic logic [31:0] fp_round(input logic sign,
                                             input logic signed [10:0] e,
                                             input logic [26:0] m);
        logic [26:0] mm;
        logic signed [10:0] ee;
        logic [5:0]  sh;
        logic        st;
        logic [24:0] r;
        logic [31:0] res;
        logic        up;
        mm = m;
        ee = e;
        // denormalize below the minimum exponent
        if (ee < -11'sd126) begin
            if ((-11'sd126 - ee) > 11'sd27)
                sh = 6'd27;
            else
                sh = 6'(-11'sd126 - ee);
            st = |(mm & ((27'd1 << sh) - 27'd1));
            mm = (mm >> sh);
            mm[0] = mm[0] | st;
            ee = -11'sd126;
        end
        up = mm[2] & (mm[1] | mm[0] | mm[3]);
        r  = {1'b0, mm[26:3]} + {24'd0, up};
        if (r[24]) begin
            r  = r >> 1;
            ee = ee + 11'sd1;
        end
        if (ee > 11'sd127)
            res = {sign, 8'hFF, 23'd0};
        else if (!r[23])
            res = {sign, 8'd0, r[22:0]};
        else
            res = {sign, 8'(ee + 11'sd127), r[22:0]};
        return res;
    endfunction

endpackage

### design/float_bf16_dot_product_top.sv
// Top level of the bf16/fp32 mixed-precision dot product.
// Each accepted word is a query/data element pair; the front multiplies it (two-stage
// pipeline, one word a cycle unless stalled) into a 4-entry queue, and the back adds
// products into an fp32 accumulator in arrival order. The accumulate loop steps through
// an align state and a round state per word and takes no new word until both are done.
// A result is produced only on a word with last_element set, after which the sum
// restarts at +0.0. Register 0 (address 0) bit 0 selects bf16 truncation of
// data_element; write it only while idle.
module float_bf16_dot_product_top
    import fbdp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_query_element,
    input  logic [31:0] s_data_element,
    input  logic        s_last_element,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_dot_product
);

    logic       data_format_reg;
    logic       f_valid;
    logic       f_ready;
    fbdp_word_t f_word;
    logic       q_valid;
    logic       q_ready;
    fbdp_word_t q_word;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[1] == RegDataFormat) ? {31'd0, data_format_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_format_reg <= 1'b0;
        end else if (psel && penable && pwrite && (paddr[1] == RegDataFormat)) begin
            data_format_reg <= pwdata[0];
        end
    end

    fbdp_front u_front (
        .aclk, .aresetn,
        .data_format (data_format_reg),
        .s_valid, .s_ready, .s_query_element, .s_data_element, .s_last_element,
        .f_valid, .f_ready, .f_word
    );

    fbdp_queue u_queue (
        .aclk, .aresetn,
        .in_valid (f_valid), .in_ready (f_ready), .in_word (f_word),
        .out_valid (q_valid), .out_ready (q_ready), .out_word (q_word)
    );

    fbdp_back u_back (
        .aclk, .aresetn,
        .q_valid, .q_ready, .q_word,
        .m_valid, .m_ready, .m_dot_product
    );

endmodule

### design/fbdp_front.sv
// Front: accepts element pairs, applies the data format and forms the rounded product.
module fbdp_front
    import fbdp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        data_format,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_query_element,
    input  logic [31:0] s_data_element,
    input  logic        s_last_element,
    output logic        f_valid,
    input  logic        f_ready,
    output fbdp_word_t  f_word
);

    // stage 1 registers: raw multiply
    logic        p1_valid_reg;
    logic [47:0] p1_man_reg;
    logic signed [10:0] p1_exp_reg;
    logic        p1_sign_reg;
    logic        p1_nan_reg;
    logic        p1_inf_reg;
    logic        p1_zero_reg;
    logic        p1_last_reg;

    // stage 2 output register
    logic        o_valid_reg;
    fbdp_word_t  o_word_reg;

    logic        adv1;
    logic        adv2;
    logic [31:0] d_eff;
    fp_unp_t     uq;
    fp_unp_t     ud;

    assign adv2    = !o_valid_reg || f_ready;
    assign adv1    = !p1_valid_reg || adv2;
    assign s_ready = adv1;
    assign f_valid = o_valid_reg;
    assign f_word  = o_word_reg;

    assign d_eff = data_format ? {s_data_element[31:Bf16Shift], 16'd0} : s_data_element;

    always_comb begin
        uq = fp_unpack(s_query_element);
        ud = fp_unpack(d_eff);
    end

    // stage 1: significand multiply and special-case classification
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (adv1) begin
            p1_valid_reg <= s_valid;
        end
        if (adv1 && s_valid) begin
            p1_man_reg  <= uq.man * ud.man;
            p1_exp_reg  <= 11'(uq.exp) + 11'(ud.exp);
            p1_sign_reg <= uq.sign ^ ud.sign;
            p1_nan_reg  <= uq.is_nan || ud.is_nan ||
                           (uq.is_inf && ud.is_zero) || (ud.is_inf && uq.is_zero);
            p1_inf_reg  <= uq.is_inf || ud.is_inf;
            p1_zero_reg <= uq.is_zero || ud.is_zero;
            p1_last_reg <= s_last_element;
        end
    end

    // stage 2: normalize and round the product
    logic [5:0]  lz;
    logic [47:0] nm;
    logic [26:0] m27;
    logic signed [10:0] ne;
    logic [31:0] prod;

    always_comb begin
        lz = 6'd47;
        for (int i = 0; i < 48; i++) begin
            if (p1_man_reg[i]) lz = 6'(47 - i);
        end
        nm  = p1_man_reg << lz;
        m27 = {nm[47:22], |nm[21:0]};
        ne  = p1_exp_reg + 11'sd1 - 11'($signed({1'b0, lz}));
        if (p1_nan_reg)
            prod = CanonNan;
        else if (p1_inf_reg)
            prod = {p1_sign_reg, 8'hFF, 23'd0};
        else if (p1_zero_reg)
            prod = {p1_sign_reg, 31'd0};
        else
            prod = fp_round(p1_sign_reg, ne, m27);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (adv2) begin
            o_valid_reg <= p1_valid_reg;
        end
        if (adv2 && p1_valid_reg) begin
            o_word_reg.prod <= prod;
            o_word_reg.last <= p1_last_reg;
        end
    end

endmodule

### design/fbdp_queue.sv
// Short queue between front and back.
module fbdp_queue
    import fbdp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  fbdp_word_t in_word,
    output logic       out_valid,
    input  logic       out_ready,
    output fbdp_word_t out_word
);

    localparam int Depth = 4;

    fbdp_word_t mem_reg [Depth];
    logic [1:0] wr_reg;
    logic [1:0] rd_reg;
    logic [2:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (cnt_reg != 3'(Depth));
    assign out_valid = (cnt_reg != 3'd0);
    assign out_word  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end else begin
            if (push) wr_reg <= wr_reg + 2'd1;
            if (pop)  rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, pop};
        end
        if (push) mem_reg[wr_reg] <= in_word;
    end

endmodule

### design/fbdp_back.sv
// Back: fp32 accumulate loop (align and round states) and the result register.
module fbdp_back
    import fbdp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  fbdp_word_t  q_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_dot_product
);

    typedef enum logic {ST_ALIGN, ST_ROUND} state_t;

    state_t      state_reg;
    logic [31:0] acc_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    // aligned-add intermediate
    logic        a_sign_reg;
    logic [27:0] a_sum_reg;
    logic signed [10:0] a_exp_reg;
    logic        a_spec_reg;
    logic [31:0] a_spec_val_reg;
    logic        a_last_reg;

    fp_unp_t     ua;
    fp_unp_t     ub;
    logic        take;

    // a word is taken only in the align state, and a last word only when the result has room
    assign take    = (state_reg == ST_ALIGN) && q_valid &&
                     (!q_word.last || !out_valid_reg || m_ready);
    assign q_ready = take;
    assign m_valid = out_valid_reg;
    assign m_dot_product = out_data_reg;

    // align and add significands (27-bit with guard bits, sticky on the small one)
    logic        big_a;
    fp_unp_t     ux;
    fp_unp_t     uy;
    logic [10:0] d;
    logic [26:0] mx;
    logic [26:0] my;
    logic [26:0] mys;
    logic        sty;
    logic [27:0] sum;
    logic        sgn;
    logic        spec;
    logic [31:0] spec_val;

    always_comb begin
        ua = fp_unpack(acc_reg);
        ub = fp_unpack(q_word.prod);
        big_a = (ua.exp > ub.exp) || ((ua.exp == ub.exp) && (ua.man >= ub.man));
        ux = big_a ? ua : ub;
        uy = big_a ? ub : ua;
        d  = 11'(ux.exp - uy.exp);
        mx = {ux.man, 3'd0};
        my = {uy.man, 3'd0};
        if (d > 11'd27) begin
            mys = 27'd0;
            sty = |my;
        end else begin
            mys = my >> d[4:0];
            sty = |(my & ((27'd1 << d[4:0]) - 27'd1));
        end
        mys[0] = mys[0] | sty;
        if (ux.sign == uy.sign) begin
            sum = {1'b0, mx} + {1'b0, mys};
            sgn = ux.sign;
        end else begin
            sum = {1'b0, mx} - {1'b0, mys};
            sgn = ux.sign;
        end
        spec     = 1'b1;
        spec_val = 32'd0;
        if (ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_inf && (ua.sign != ub.sign)))
            spec_val = CanonNan;
        else if (ua.is_inf)
            spec_val = acc_reg;
        else if (ub.is_inf)
            spec_val = q_word.prod;
        else if (ua.is_zero && ub.is_zero)
            spec_val = {ua.sign & ub.sign, 31'd0};
        else if (sum == 28'd0)
            spec_val = 32'd0;
        else
            spec = 1'b0;
    end

    // normalize the sum and round
    logic [4:0]  lz;
    logic [27:0] ns;
    logic [26:0] m27;
    logic signed [10:0] ne;
    logic [31:0] rsum;

    always_comb begin
        lz = 5'd27;
        for (int i = 0; i < 28; i++) begin
            if (a_sum_reg[i]) lz = 5'(27 - i);
        end
        ns  = a_sum_reg << lz;
        m27 = {ns[27:2], |ns[1:0]};
        ne  = a_exp_reg + 11'sd1 - 11'($signed({1'b0, lz}));
        if (a_spec_reg)
            rsum = a_spec_val_reg;
        else
            rsum = fp_round(a_sign_reg, ne, m27);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ALIGN;
            acc_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_ALIGN: begin
                    if (take) begin
                        a_sign_reg     <= sgn;
                        a_sum_reg      <= sum;
                        a_exp_reg      <= 11'(ux.exp);
                        a_spec_reg     <= spec;
                        a_spec_val_reg <= spec_val;
                        a_last_reg     <= q_word.last;
                        state_reg      <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    if (a_last_reg) begin
                        acc_reg       <= 32'd0;
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= rsum;
                    end else begin
                        acc_reg <= rsum;
                    end
                    state_reg <= ST_ALIGN;
                end
                default: state_reg <= ST_ALIGN;
            endcase
        end
    end

endmodule

### design/fbdp_checker.sv
// Port-level checker for the dot product top level, with its bind.
module fbdp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_dot_product,
    input logic        pready
);

    // a result word holds while stalled
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dot_product))
        else $error("result word changed while stalled");

    // no result right out of reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // config port never waits
    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

    // no result in the first cycle after reset is released
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result right after reset release");

endmodule

bind float_bf16_dot_product_top fbdp_checker u_fbdp_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_dot_product, .pready
);

### bench/tb_float_bf16_dot_product_top.sv
// Self-checking testbench for the bf16/fp32 mixed-precision dot product block.
`timescale 1ns / 1ps

module tb_float_bf16_dot_product_top
    import fbdp_pkg::*;
();

    localparam int unsigned CycleLimit = 2_000_000;
    localparam int unsigned DrainCycles = 20;

    // traffic shaping modes
    typedef enum logic [1:0] {
        MODE_SEND_IDLE,
        MODE_RECV_IDLE,
        MODE_NO_IDLE
    } idle_mode_t;

    // one row of the directed table
    typedef struct {
        logic [31:0] query;
        logic [31:0] data;
        logic        last;
        logic        known;     // expected sum typed in below
        logic [31:0] sum;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_query_element;
    logic [31:0] s_data_element;
    logic        s_last_element;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_dot_product;

    // expectation attached to the word on the input port
    logic        word_known;
    logic [31:0] word_sum;

    logic [31:0] sum_queue[$];
    logic [31:0] acc_model;
    logic        bf16_mode;
    idle_mode_t  idle_mode;
    logic        hold_req;
    int unsigned err_count;
    int unsigned words_in;
    int unsigned sums_out;
    int unsigned cycle_count;

    float_bf16_dot_product_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_query_element (s_query_element),
        .s_data_element  (s_data_element),
        .s_last_element  (s_last_element),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_dot_product   (m_dot_product)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- IEEE single arithmetic ----------------

    function automatic logic is_nan32(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf32(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    endfunction

    // round sign * mag * 2^e to nearest even single
    function automatic logic [31:0] round_single(input logic s, input logic [63:0] mag,
                                                 input int e);
        int p;
        int qe;
        int sh;
        int be;
        logic [63:0] keep;
        logic [63:0] rem;
        logic [63:0] half;
        if (mag == 64'd0)
            return {s, 31'd0};
        p = 63;
        while (!mag[p])
            p--;
        qe = (p + e - 23 > -149) ? p + e - 23 : -149;
        sh = qe - e;
        if (sh <= 0) begin
            keep = mag << (-sh);
        end else if (sh >= 64) begin
            keep = 64'd0;
        end else begin
            keep = mag >> sh;
            rem  = mag & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && keep[0]))
                keep = keep + 64'd1;
        end
        if (keep[24]) begin
            keep = keep >> 1;
            qe++;
        end
        if (!keep[23])
            return {s, 8'd0, keep[22:0]};
        be = qe + 150;
        if (be >= 255)
            return {s, 8'hFF, 23'd0};
        return {s, 8'(be), keep[22:0]};
    endfunction

    function automatic logic [31:0] mul_single(input logic [31:0] a, input logic [31:0] b);
        logic s;
        int ea;
        int eb;
        logic [63:0] ma;
        logic [63:0] mb;
        s = a[31] ^ b[31];
        if (is_nan32(a) || is_nan32(b))
            return CanonNan;
        if (is_inf32(a) || is_inf32(b)) begin
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0)
                return CanonNan;
            return {s, 8'hFF, 23'd0};
        end
        ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
        ma = {40'd0, (a[30:23] != 8'd0), a[22:0]};
        mb = {40'd0, (b[30:23] != 8'd0), b[22:0]};
        return round_single(s, ma * mb, ea + eb - 300);
    endfunction

    function automatic logic [31:0] add_single(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] t;
        logic s;
        int ea;
        int eb;
        int diff;
        int e;
        logic [63:0] big;
        logic [63:0] tiny;
        logic [63:0] mag;
        if (is_nan32(a) || is_nan32(b))
            return CanonNan;
        if (is_inf32(a) && is_inf32(b))
            return (a[31] == b[31]) ? a : CanonNan;
        if (is_inf32(a))
            return a;
        if (is_inf32(b))
            return b;
        ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
        eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
        if (ea < eb) begin
            t = a; a = b; b = t;
            diff = ea; ea = eb; eb = diff;
        end
        diff = ea - eb;
        big  = {40'd0, (a[30:23] != 8'd0), a[22:0]};
        tiny = {40'd0, (b[30:23] != 8'd0), b[22:0]};
        // far below the rounding point the small term only acts as sticky
        if (diff > 30) begin
            big  = big << 30;
            tiny = (tiny != 64'd0) ? 64'd1 : 64'd0;
            e    = ea - 180;
        end else begin
            big = big << diff;
            e   = eb - 150;
        end
        if (a[31] == b[31]) begin
            mag = big + tiny;
            s   = a[31];
        end else if (big >= tiny) begin
            mag = big - tiny;
            s   = a[31];
        end else begin
            mag = tiny - big;
            s   = b[31];
        end
        if (mag == 64'd0)
            s = a[31] & b[31];
        return round_single(s, mag, e);
    endfunction

    // accumulate one pair; returns 1 and the sum when the vector closes
    function automatic logic accumulate_pair(input logic [31:0] q, input logic [31:0] d,
                                             input logic last, output logic [31:0] sum);
        logic [31:0] dd;
        dd = bf16_mode ? {d[31:16], 16'h0000} : d;
        sum = add_single(acc_model, mul_single(q, dd));
        acc_model = last ? 32'h0000_0000 : sum;
        return last;
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0d] mismatch %s: got %h want %h", cycle_count, what, got, want);
        err_count++;
    endtask

    // input word accepted: predict
    always @(posedge aclk) begin
        logic [31:0] sum;
        if (aresetn && s_valid && s_ready) begin
            words_in++;
            if (accumulate_pair(s_query_element, s_data_element, s_last_element, sum))
                sum_queue.push_back(word_known ? word_sum : sum);
        end
    end

    // result word accepted: compare
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sums_out++;
            if (sum_queue.size() == 0)
                report_mismatch("unexpected dot_product", m_dot_product, 32'h0);
            else if (m_dot_product !== sum_queue[0])
                report_mismatch("dot_product", m_dot_product, sum_queue.pop_front());
            else
                void'(sum_queue.pop_front());
        end
    end

    // receiver back-pressure, with one long hold-off on request
    always @(posedge aclk) begin
        int unsigned hold_left;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left = 0;
        end else if (hold_req && hold_left == 0) begin
            hold_left = 400;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= (hold_left == 0);
        end else if (idle_mode == MODE_RECV_IDLE) begin
            m_ready <= ($urandom_range(99) >= 32);
        end else if (idle_mode == MODE_SEND_IDLE) begin
            m_ready <= ($urandom_range(99) >= 65);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------- stimulus ----------------

    task automatic cfg_write(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'(RegDataFormat) << 2;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        bf16_mode = value[0];
        // read back
        @(posedge aclk);
        psel <= 1'b1;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[0] !== bf16_mode)
            report_mismatch("data_format readback", prdata, {31'd0, bf16_mode});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // quiet the block before touching the register; first let the last
    // accepted word reach the predictor
    task automatic wait_drained();
        @(posedge aclk);
        while (sum_queue.size() != 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic send_word(input logic [31:0] q, input logic [31:0] d, input logic last,
                             input logic known, input logic [31:0] sum);
        int unsigned gap;
        int unsigned idle_pct;
        s_valid         <= 1'b1;
        s_query_element <= q;
        s_data_element  <= d;
        s_last_element  <= last;
        word_known      <= known;
        word_sum        <= sum;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // sender idles cycle by cycle at the mode's rate
        if (idle_mode == MODE_SEND_IDLE)
            idle_pct = 32;
        else if (idle_mode == MODE_RECV_IDLE)
            idle_pct = 65;
        else
            idle_pct = 0;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] rand_operand();
        int unsigned pick;
        logic [31:0] v;
        pick = $urandom_range(99);
        v = $urandom();
        if (pick < 55)
            v[30:23] = 8'($urandom_range(134, 118));
        else if (pick < 62)
            v[30:0] = 31'd0;
        else if (pick < 67)
            v[30:0] = {8'hFF, 23'd0};
        else if (pick < 70)
            v[30:23] = 8'hFF;
        else if (pick < 78)
            v[30:23] = 8'd0;
        else if (pick < 84)
            v[30:23] = 8'($urandom_range(254, 240));
        else if (pick < 90)
            v[30:23] = 8'($urandom_range(40, 1));
        return v;
    endfunction

    task automatic random_phase(input int unsigned n_words, input logic pause_once);
        int unsigned left;
        int unsigned len;
        int unsigned i;
        left = n_words;
        while (left > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            if (len > left)
                len = left;
            for (i = 0; i < len; i++)
                send_word(rand_operand(), rand_operand(), (i == len - 1), 1'b0, 32'h0);
            left -= len;
            if (pause_once && left < n_words / 2) begin
                s_valid <= 1'b0;
                pause_once = 1'b0;
                while (sum_queue.size() != 0)
                    @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
    endtask

    dir_row_t dir_rows[] = '{
        '{32'h3F80_0000, 32'h3F80_0000, 1'b1, 1'b1, 32'h3F80_0000},  // 1 * 1
        '{32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},  // -0 * +0 plus +0
        '{32'h7FC0_0001, 32'h3F80_0000, 1'b1, 1'b1, CanonNan},       // NaN in
        '{32'h7F80_0000, 32'h0000_0000, 1'b1, 1'b1, CanonNan},       // inf * 0
        '{32'h7F80_0000, 32'h3F80_0000, 1'b1, 1'b1, 32'h7F80_0000},  // inf * 1
        '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1, 1'b1, 32'h7F80_0000},  // overflow
        '{32'h0000_0001, 32'h3F00_0000, 1'b1, 1'b1, 32'h0000_0000},  // tie to even zero
        '{32'h7F80_0000, 32'h3F80_0000, 1'b0, 1'b0, 32'h0},          // +inf then -inf
        '{32'hFF80_0000, 32'h3F80_0000, 1'b1, 1'b1, CanonNan},
        '{32'hFFFF_FFFF, 32'h3F80_0000, 1'b0, 1'b0, 32'h0},          // NaN sticks
        '{32'h3F80_0000, 32'h3F80_0000, 1'b1, 1'b1, CanonNan},
        '{32'h0000_0001, 32'h0000_0001, 1'b1, 1'b1, 32'h0000_0000},  // subnormal squared
        '{32'h007F_FFFF, 32'h4000_0000, 1'b0, 1'b0, 32'h0},          // subnormal to normal
        '{32'h8080_0000, 32'h3F00_0000, 1'b1, 1'b0, 32'h0},
        '{32'h3FC0_0000, 32'h4020_1234, 1'b0, 1'b0, 32'h0},
        '{32'hC000_0000, 32'h3FAB_CDEF, 1'b0, 1'b0, 32'h0},
        '{32'h3380_0000, 32'h3F80_0001, 1'b1, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, CanonNan},
        '{32'h3F80_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0}
    };

    initial begin
        aresetn         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = 2'd0;
        pwdata          = 32'd0;
        s_valid         = 1'b0;
        s_query_element = 32'd0;
        s_data_element  = 32'd0;
        s_last_element  = 1'b0;
        word_known      = 1'b0;
        word_sum        = 32'd0;
        acc_model       = 32'h0000_0000;
        bf16_mode       = 1'b0;
        idle_mode       = MODE_NO_IDLE;
        hold_req        = 1'b0;
        err_count       = 0;
        words_in        = 0;
        sums_out        = 0;
        cycle_count     = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words, fp32 mode straight out of reset
        idle_mode = MODE_SEND_IDLE;
        foreach (dir_rows[i])
            send_word(dir_rows[i].query, dir_rows[i].data, dir_rows[i].last,
                      dir_rows[i].known, dir_rows[i].sum);
        s_valid <= 1'b0;
        word_known <= 1'b0;
        wait_drained();

        // bf16 mode, with the sender idling less often than the receiver stalls
        cfg_write(32'h0000_0001);
        // low half of data dropped: 1.0 with junk below stays 1.0
        send_word(32'h3F80_0000, 32'h3F80_FFFF, 1'b1, 1'b1, 32'h3F80_0000);
        s_valid <= 1'b0;
        random_phase(600, 1'b0);
        wait_drained();

        // fp32 again, idle rates swapped, with one long hold-off
        cfg_write(32'hFFFF_FFFE);
        idle_mode = MODE_RECV_IDLE;
        fork
            random_phase(600, 1'b0);
            begin
                repeat (200) @(posedge aclk);
                hold_req <= 1'b1;
                @(posedge aclk);
                hold_req <= 1'b0;
            end
        join
        wait_drained();

        // bf16, full rate, one pause until the block is empty
        cfg_write(32'hFFFF_FFFF);
        idle_mode = MODE_NO_IDLE;
        random_phase(600, 1'b1);
        wait_drained();
        cfg_write(32'h0000_0000);

        $display("covered %0d element pairs and %0d dot products over fp32 and bf16 modes,",
                 words_in, sums_out);
        $display("with specials, subnormals, stalls on both sides and a long result hold-off");
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", err_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule
